FILE: rtl/sc32h_pkg.sv
// Shared types, constants and functions for the seeded CRC32C block hash.
// No dependencies; every other file imports this package.
`default_nettype none

package sc32h_pkg;

    // Field widths
    localparam int unsigned WORD_W  = 32;
    localparam int unsigned VBYTE_W = 3;

    // Seed scrambler constants (xorshift64*)
    localparam int unsigned SHIFT_A = 12;
    localparam int unsigned SHIFT_B = 25;
    localparam int unsigned SHIFT_C = 27;
    // Only the low half of the multiplier reaches the low 32 bits of the product
    localparam logic [31:0] SCR_MULT_LO = 32'h4F6C_DD1D;

    // Reflected Castagnoli polynomial
    localparam logic [31:0] CRC_POLY = 32'h82F6_3B78;

    // Byte counts
    localparam logic [VBYTE_W-1:0] VB_NONE  = 3'd0;
    localparam logic [VBYTE_W-1:0] VB_ONE   = 3'd1;
    localparam logic [VBYTE_W-1:0] VB_TWO   = 3'd2;
    localparam logic [VBYTE_W-1:0] VB_THREE = 3'd3;
    localparam logic [VBYTE_W-1:0] VB_FULL  = 3'd4;

    // Default depth of the queue between front and back
    localparam int unsigned QUEUE_DEPTH_DEF = 2;

    // One classified word waiting for the CRC stage
    typedef struct packed {
        logic [WORD_W-1:0] word;   // bytes past the valid count already zeroed
        logic              empty;  // no valid bytes: value passes unchanged
        logic              last;   // closes the block
    } t_work;

    // Queue to back-end handshake
    typedef struct packed {
        logic  valid;
        t_work item;
    } t_queue_head;

    // CRC32C of a single set bit at position idx run through 32 shift steps.
    // Used only for elaboration-time constants.
    function automatic logic [31:0] crc_col(input int unsigned idx);
        logic [31:0] c;
        c = 32'd1 << idx;
        for (int k = 0; k < 32; k++) begin
            c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/sc32h_if.sv
// Channel interfaces for the seeded CRC32C block hash: input words, results, seed writes.
// Depends on sc32h_pkg.
`default_nettype none

interface sc32h_in_if
    import sc32h_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [WORD_W-1:0]  data_word;
    logic [VBYTE_W-1:0] valid_bytes;
    logic               last_word;

    modport source (output valid, data_word, valid_bytes, last_word, input ready);
    modport sink   (input valid, data_word, valid_bytes, last_word, output ready);
endinterface

interface sc32h_out_if
    import sc32h_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] block_hash;

    modport source (output valid, block_hash, input ready);
    modport sink   (input valid, block_hash, output ready);
endinterface

interface sc32h_cfg_if
    import sc32h_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] seed;

    modport source (output valid, seed, input ready);
    modport sink   (input valid, seed, output ready);
endinterface

`default_nettype wire

FILE: rtl/sc32h_seed.sv
// Seed register and xorshift64* scrambler producing the block start value.
// Depends on sc32h_pkg.
`default_nettype none

module sc32h_seed
    import sc32h_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_wr,
    input  wire logic [31:0] i_seed,
    output logic [31:0]      o_seed_scr
);

    logic [63:0] w_x0;
    logic [63:0] w_x1;
    logic [63:0] w_x2;
    logic [31:0] w_x3;
    logic [31:0] r_xlo;
    logic [31:0] r_scr;
    logic        r_mul_pend;

    // Sign-extend and xorshift; only XOR and wiring
    always_comb begin
        w_x0 = {{32{i_seed[31]}}, i_seed};
        w_x1 = w_x0 ^ (w_x0 >> SHIFT_A);
        w_x2 = w_x1 ^ (w_x1 << SHIFT_B);
        w_x3 = w_x2[31:0] ^ w_x2[SHIFT_C+31:SHIFT_C];
    end

    // Stage 1 holds the xorshifted low word, stage 2 the low product.
    // Scrambled seed of zero is zero, so reset clears both.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_xlo      <= '0;
            r_scr      <= '0;
            r_mul_pend <= 1'b0;
        end else begin
            r_mul_pend <= i_wr;
            if (i_wr) begin
                r_xlo <= w_x3;
            end
            if (r_mul_pend) begin
                r_scr <= r_xlo * SCR_MULT_LO;
            end
        end
    end

    assign o_seed_scr = r_scr;

    // Product lands the cycle after the xorshift stage
    a_mul_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mul_pend |=> r_scr == 32'($past(r_xlo) * SCR_MULT_LO))
        else $error("scrambled seed not updated from xorshift stage");

endmodule

`default_nettype wire

FILE: rtl/sc32h_front.sv
// Front end: accepts words, clamps the byte count, masks unused bytes, queues work.
// Depends on sc32h_pkg and sc32h_if.
`default_nettype none

module sc32h_front
    import sc32h_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    sc32h_in_if.sink    i_in,
    input  wire logic   i_pop,
    output t_queue_head o_head
);

    localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    t_work            r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic [31:0]      w_mask;
    t_work            w_item;
    logic             w_push;
    logic             w_pop;

    // Byte count clamp and mask; counts above four act as four
    always_comb begin
        case (i_in.valid_bytes)
            VB_NONE:  w_mask = 32'h0000_0000;
            VB_ONE:   w_mask = 32'h0000_00FF;
            VB_TWO:   w_mask = 32'h0000_FFFF;
            VB_THREE: w_mask = 32'h00FF_FFFF;
            default:  w_mask = 32'hFFFF_FFFF;
        endcase
        w_item.word  = i_in.data_word & w_mask;
        w_item.empty = (i_in.valid_bytes == VB_NONE);
        w_item.last  = i_in.last_word;
    end

    assign i_in.ready = (r_count != CNT_FULL);
    assign w_push     = i_in.valid && i_in.ready;
    assign w_pop      = i_pop && (r_count != '0);

    // Queue storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= w_item;
        end
    end

    // Queue pointers and fill count
    always_comb begin
        n_count = r_count;
        if (w_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (w_pop && !w_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
            end
        end
    end

    assign o_head.valid = (r_count != '0);
    assign o_head.item  = r_mem[r_rd_ptr];

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_FULL)
        else $error("queue count beyond depth");

    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && !w_pop) |=> r_count == $past(r_count) + 1'b1)
        else $error("queue count did not grow on push");

endmodule

`default_nettype wire

FILE: rtl/sc32h_back.sv
// Back end: CRC32C word step on queued work and the registered result stage.
// Depends on sc32h_pkg and sc32h_if.
`default_nettype none

module sc32h_back
    import sc32h_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_queue_head i_head,
    input  wire logic [31:0] i_seed_scr,
    output logic             o_pop,
    sc32h_out_if.source      o_out
);

    logic [31:0] w_cols [32];
    logic [31:0] r_crc;
    logic        r_in_block;
    logic        r_out_valid;
    logic [31:0] r_hash;
    logic [31:0] w_base;
    logic [31:0] w_mix;
    logic [31:0] w_step;
    logic [31:0] w_next;

    // Each input bit's contribution after 32 shift steps
    for (genvar g = 0; g < 32; g++) begin : g_col
        localparam logic [31:0] COL = crc_col(g);
        assign w_cols[g] = w_mix[g] ? COL : 32'd0;
    end

    // Word step: start value, XOR with data, fold through the column table
    always_comb begin
        w_base = r_in_block ? r_crc : i_seed_scr;
        w_mix  = w_base ^ i_head.item.word;
        w_step = '0;
        for (int i = 0; i < 32; i++) begin
            w_step = w_step ^ w_cols[i];
        end
        w_next = i_head.item.empty ? w_base : w_step;
    end

    // Only a closing word needs the result slot
    assign o_pop = i_head.valid && (!i_head.item.last || !r_out_valid || o_out.ready);

    // Running value and block state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_block <= 1'b0;
        end else if (o_pop) begin
            r_in_block <= !i_head.item.last;
        end
        if (o_pop) begin
            r_crc <= w_next;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_pop && i_head.item.last) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
        if (o_pop && i_head.item.last) begin
            r_hash <= w_next;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.block_hash = r_hash;

    a_block_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && i_head.item.last) |=> !r_in_block && r_out_valid)
        else $error("block did not close on last word");

    a_empty_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && i_head.item.last && i_head.item.empty && !r_in_block)
        |=> r_hash == $past(i_seed_scr))
        else $error("empty block did not return scrambled seed");

endmodule

`default_nettype wire

FILE: rtl/seeded_crc32c_block_hash_top.sv
// Top level of the seeded CRC32C block hash: seed scrambler, front queue, CRC back end.
// Depends on sc32h_pkg, sc32h_if, sc32h_seed, sc32h_front, sc32h_back.
`default_nettype none

// Hashes a block of little-endian 32-bit words with a 32-bit CRC32C step per word,
// starting from the low word of the xorshift64*-scrambled seed. One word is taken
// every clock while the queue has room; the full CRC step is a combinational XOR
// network in the back end, so throughput is one word per cycle unless a closing
// word waits for the result register to be taken. The hash appears on the output
// register in the cycle after its closing word leaves the queue. The result register
// lets the next block stream in while a hash waits to be taken. A seed write passes
// a registered xorshift stage, then a 32x32 multiply stage, to reach the scrambled
// start value and applies from the next block on; the seed port is always ready.
module seeded_crc32c_block_hash_top
    import sc32h_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    sc32h_cfg_if.sink   i_cfg,
    sc32h_in_if.sink    i_in,
    sc32h_out_if.source o_out
);

    logic        w_pop;
    t_queue_head w_head;
    logic [31:0] w_seed_scr;

    // Seed port never stalls
    assign i_cfg.ready = 1'b1;

    sc32h_seed u_seed (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr       (i_cfg.valid),
        .i_seed     (i_cfg.seed),
        .o_seed_scr (w_seed_scr)
    );

    sc32h_front #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_pop   (w_pop),
        .o_head  (w_head)
    );

    sc32h_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (w_head),
        .i_seed_scr (w_seed_scr),
        .o_pop      (w_pop),
        .o_out      (o_out)
    );

endmodule

`default_nettype wire
